// File: hdl/mp2s_pkg.sv
package mp2s_pkg;

  // Fixed widths of the configuration registers
  localparam int KERNEL_REG_BITS = 4;
  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 13;
  localparam int CFG_DATA_BITS   = 13;

  localparam int HEIGHT_LIMIT = 4096;
  localparam int ROW_BITS     = 12;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_KERNEL  = 8;
  localparam int DEF_SAMPLE_BITS = 16;

  // Reset values of the configuration registers
  localparam logic [KERNEL_REG_BITS-1:0] KERNEL_H_RST = KERNEL_REG_BITS'(2);
  localparam logic [KERNEL_REG_BITS-1:0] KERNEL_W_RST = KERNEL_REG_BITS'(2);
  localparam logic [WIDTH_REG_BITS-1:0]  IMAGE_W_RST  = WIDTH_REG_BITS'(1024);
  localparam logic [HEIGHT_REG_BITS-1:0] IMAGE_H_RST  = HEIGHT_REG_BITS'(4096);

  typedef enum logic [1:0] {
    REG_KERNEL_HEIGHT = 2'd0,
    REG_KERNEL_WIDTH  = 2'd1,
    REG_IMAGE_WIDTH   = 2'd2,
    REG_IMAGE_HEIGHT  = 2'd3
  } reg_idx_e;

endpackage

// File: hdl/mp2s_line_store.sv
module mp2s_line_store #(
  parameter int DEPTH     = 1024,
  parameter int ROW_WIDTH = 112
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [ROW_WIDTH-1:0]     wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [ROW_WIDTH-1:0]     rd_data_o
);

  logic [ROW_WIDTH-1:0] mem_q [DEPTH];
  logic [ROW_WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Same column read straight back (one-column images): take the fresh row
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      rd_q <= wr_data_i;
    end else begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// File: hdl/mp2s_cell.sv
module mp2s_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic                          active_i,
  input  logic signed [SAMPLE_BITS-1:0] value_i,
  output logic signed [SAMPLE_BITS-1:0] value_o,
  output logic signed [SAMPLE_BITS-1:0] contrib_o
);

  localparam logic signed [SAMPLE_BITS-1:0] MinVal = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] value_q;
  logic signed [SAMPLE_BITS-1:0] value_d;

  assign value_d = shift_i ? value_i : value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  assign value_o   = value_q;
  // outside the kernel width the cell drops out of the maximum
  assign contrib_o = active_i ? value_q : MinVal;

endmodule

// File: hdl/mp2s_max_tree.sv
module mp2s_max_tree #(
  parameter int N           = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic signed [SAMPLE_BITS-1:0] val_i [N],
  output logic signed [SAMPLE_BITS-1:0] max_o
);

  localparam int P = 1 << $clog2(N);
  localparam logic signed [SAMPLE_BITS-1:0] MinVal = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // node 0 is the root, leaves sit at P-1 .. 2P-2
  logic signed [SAMPLE_BITS-1:0] node [2*P-1];

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign node[P-1+i] = val_i[i];
    end else begin : g_pad
      assign node[P-1+i] = MinVal;
    end
  end

  for (genvar i = 0; i < P-1; i++) begin : g_node
    assign node[i] = (node[2*i+1] > node[2*i+2]) ? node[2*i+1] : node[2*i+2];
  end

  assign max_o = node[0];

endmodule

// File: hdl/max_pool_2d_stream.sv
// Stride-1 2D max pooling over a raster stream of signed samples. One sample
// beat is taken every clock unless the output stalls; results pass a pending
// stage and an output register, and planes follow each other with no gap. The
// line store reads the column history of the next sample while it writes back
// the updated history of the current one, which holds the rate at one beat per
// clock. The column maxima run through a row of MAX_KERNEL cells; the
// horizontal maximum over the cells inside the window width is registered into
// the output stage, so a beat is still taken while a result waits there with
// the pending stage empty. Configuration must be written only when no beat is
// in flight; the block does not enforce it. There is no clearing pass after
// reset, as a line store entry is always written before a result depends on it.
module max_pool_2d_stream #(
  parameter int MAX_WIDTH   = mp2s_pkg::DEF_MAX_WIDTH,
  parameter int MAX_KERNEL  = mp2s_pkg::DEF_MAX_KERNEL,
  parameter int SAMPLE_BITS = mp2s_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]        max_value_o,
  output logic                                 last_of_plane_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  mp2s_pkg::reg_idx_e                   cfg_index_i,
  input  logic [mp2s_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);

  import mp2s_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int KB = $clog2(MAX_KERNEL + 1);
  localparam int HB = $clog2(HEIGHT_LIMIT + 1);
  localparam int NH = MAX_KERNEL - 1;
  localparam int SB = SAMPLE_BITS;
  localparam logic signed [SB-1:0] MinVal = {1'b1, {(SB-1){1'b0}}};

  // Configuration registers
  logic [KERNEL_REG_BITS-1:0] kh_q, kw_q;
  logic [WIDTH_REG_BITS-1:0]  img_w_q;
  logic [HEIGHT_REG_BITS-1:0] img_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kh_q    <= KERNEL_H_RST;
      kw_q    <= KERNEL_W_RST;
      img_w_q <= IMAGE_W_RST;
      img_h_q <= IMAGE_H_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_KERNEL_HEIGHT: kh_q    <= cfg_data_i[KERNEL_REG_BITS-1:0];
        REG_KERNEL_WIDTH:  kw_q    <= cfg_data_i[KERNEL_REG_BITS-1:0];
        REG_IMAGE_WIDTH:   img_w_q <= cfg_data_i[WIDTH_REG_BITS-1:0];
        REG_IMAGE_HEIGHT:  img_h_q <= cfg_data_i[HEIGHT_REG_BITS-1:0];
      endcase
    end
  end

  // Clamped working values
  logic [KB-1:0] kh, kw;
  logic [WW-1:0] w;
  logic [HB-1:0] h;

  always_comb begin
    if (kh_q == '0) begin
      kh = KB'(1);
    end else if (32'(kh_q) > 32'(MAX_KERNEL)) begin
      kh = KB'(MAX_KERNEL);
    end else begin
      kh = KB'(kh_q);
    end
    if (kw_q == '0) begin
      kw = KB'(1);
    end else if (32'(kw_q) > 32'(MAX_KERNEL)) begin
      kw = KB'(MAX_KERNEL);
    end else begin
      kw = KB'(kw_q);
    end
    if (img_w_q == '0) begin
      w = WW'(1);
    end else if (32'(img_w_q) > 32'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(img_w_q);
    end
    if (img_h_q == '0) begin
      h = HB'(1);
    end else if (32'(img_h_q) > 32'(HEIGHT_LIMIT)) begin
      h = HB'(HEIGHT_LIMIT);
    end else begin
      h = HB'(img_h_q);
    end
  end

  // Handshake and pipeline control
  logic in_acc, move;
  logic p_valid_q, p_valid_d, p_last_q;
  logic out_valid_q, out_valid_d, out_last_q;
  logic signed [SB-1:0] out_max_q;

  assign move       = p_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !p_valid_q || move;
  assign in_acc     = in_valid_i && in_ready_o;

  // Raster position of the next beat
  logic [CW-1:0]       col_q, col_d;
  logic [ROW_BITS-1:0] row_q, row_d;
  logic [WW-1:0]       col_inc;
  logic [HB-1:0]       row_inc;
  logic                produce, last_now;

  always_comb begin
    col_inc = WW'(col_q) + WW'(1);
    row_inc = HB'(row_q) + HB'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (in_acc) begin
      if (col_inc >= w) begin
        col_d = '0;
        row_d = (row_inc >= h) ? '0 : row_inc[ROW_BITS-1:0];
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  assign produce  = (32'(row_q) + 32'd1 >= 32'(kh)) && (32'(col_q) + 32'd1 >= 32'(kw)) &&
                    (32'(row_q) < 32'(h)) && (32'(col_q) < 32'(w));
  assign last_now = (32'(row_q) + 32'd1 >= 32'(h)) && (32'(col_q) + 32'd1 >= 32'(w));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line store: one row per column, holding the NH previous samples
  logic [NH*SB-1:0] rd_row, wr_row;
  logic signed [SB-1:0] hist [NH];

  always_comb begin
    for (int j = 0; j < NH; j++) begin
      hist[j] = rd_row[j*SB +: SB];
    end
    wr_row[SB-1:0] = sample_i;
    for (int j = 1; j < NH; j++) begin
      wr_row[j*SB +: SB] = hist[j-1];
    end
  end

  mp2s_line_store #(
    .DEPTH     (MAX_WIDTH),
    .ROW_WIDTH (NH*SB)
  ) u_line_store (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc),
    .wr_addr_i (col_q),
    .wr_data_i (wr_row),
    .rd_addr_i (col_d),
    .rd_data_o (rd_row)
  );

  // Vertical maximum over the sample and the kh-1 rows above it
  logic signed [SB-1:0] vleaf [MAX_KERNEL];
  logic signed [SB-1:0] cmax;

  always_comb begin
    vleaf[0] = sample_i;
    for (int j = 0; j < NH; j++) begin
      vleaf[j+1] = (32'(j) + 32'd1 < 32'(kh)) ? hist[j] : MinVal;
    end
  end

  mp2s_max_tree #(
    .N           (MAX_KERNEL),
    .SAMPLE_BITS (SB)
  ) u_vtree (
    .val_i (vleaf),
    .max_o (cmax)
  );

  // Row of column-maximum cells, newest first
  logic signed [SB-1:0] cell_in   [MAX_KERNEL];
  logic signed [SB-1:0] cell_val  [MAX_KERNEL];
  logic signed [SB-1:0] cell_cont [MAX_KERNEL];
  logic signed [SB-1:0] hmax;

  for (genvar j = 0; j < MAX_KERNEL; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign cell_in[j] = cmax;
    end else begin : g_link
      assign cell_in[j] = cell_val[j-1];
    end

    mp2s_cell #(
      .SAMPLE_BITS (SB)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (in_acc),
      .active_i  (32'(j) < 32'(kw)),
      .value_i   (cell_in[j]),
      .value_o   (cell_val[j]),
      .contrib_o (cell_cont[j])
    );
  end

  mp2s_max_tree #(
    .N           (MAX_KERNEL),
    .SAMPLE_BITS (SB)
  ) u_htree (
    .val_i (cell_cont),
    .max_o (hmax)
  );

  // Pending stage (window sits in the cells) and output register
  always_comb begin
    if (in_acc) begin
      p_valid_d = produce;
    end else if (move) begin
      p_valid_d = 1'b0;
    end else begin
      p_valid_d = p_valid_q;
    end
    if (move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p_valid_q   <= p_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p_last_q <= last_now;
    end
    if (move) begin
      out_max_q  <= hmax;
      out_last_q <= p_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign max_value_o     = out_max_q;
  assign last_of_plane_o = out_last_q;

  a_ready_when_empty : assert property (
    @(posedge clk_i) disable iff (!rst_ni) !p_valid_q |-> in_ready_o
  ) else $error("input stalled with no pending window");

  a_pending_moves : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (p_valid_q && !out_valid_q) |=> out_valid_o
  ) else $error("pending window not passed to a free output register");

  a_window_pending : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (in_acc && produce) |=> p_valid_q
  ) else $error("completed window beat lost");

  a_no_stall_loss : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (p_valid_q && !move) |=> p_valid_q
  ) else $error("pending window dropped while output stalled");

endmodule

// File: verif/max_pool_2d_stream_test.sv
module max_pool_2d_stream_test;
  import mp2s_pkg::*;

  localparam int MAXW         = DEF_MAX_WIDTH;
  localparam int MAXK         = DEF_MAX_KERNEL;
  localparam int SBITS        = DEF_SAMPLE_BITS;
  localparam int DRAIN        = 8;
  localparam int RANDOM_ITEMS = 1760;
  localparam int HOLD_CYCLES  = 200;

  typedef struct {
    logic signed [SBITS-1:0] value;
    logic                    last;
  } pooled_t;

  typedef enum {DO_WRITE, DO_SAMPLE, DO_ALIGN} step_kind_e;
  typedef enum {EXP_PREDICTED, EXP_NONE, EXP_VALUE} exp_kind_e;

  typedef struct {
    step_kind_e               kind;
    reg_idx_e                 idx;
    logic [CFG_DATA_BITS-1:0] data;
    logic signed [SBITS-1:0]  sample;
    exp_kind_e                chk;
    logic signed [SBITS-1:0]  value;
    logic                     last;
  } plan_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [SBITS-1:0]  sample_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [SBITS-1:0]  max_value_o;
  logic                     last_of_plane_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  reg_idx_e                 cfg_index_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  max_pool_2d_stream dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sample_i,
    .out_valid_o,
    .out_ready_i,
    .max_value_o,
    .last_of_plane_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // Register shadows and pooling state of the predictor
  logic [KERNEL_REG_BITS-1:0] kh_reg = KERNEL_H_RST;
  logic [KERNEL_REG_BITS-1:0] kw_reg = KERNEL_W_RST;
  logic [WIDTH_REG_BITS-1:0]  w_reg  = IMAGE_W_RST;
  logic [HEIGHT_REG_BITS-1:0] h_reg  = IMAGE_H_RST;
  bit signed [SBITS-1:0] col_hist [MAXK-1][MAXW];
  bit signed [SBITS-1:0] colmax_win [MAXK];
  int col_pos = 0;
  int row_pos = 0;

  pooled_t pending [$];
  int errors = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int writes_done = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cnt = 0;

  plan_t plan [40] = '{
    // reset setting: first row of a 2x2 kernel gives nothing
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'sh7FFF, EXP_NONE, 0, 0},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'sh8000, EXP_NONE, 0, 0},
    // shrink width then height mid-plane, back to the origin
    '{DO_WRITE, REG_IMAGE_WIDTH, 1, 0, EXP_PREDICTED, 0, 0},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'sh1234, EXP_NONE, 0, 0},
    '{DO_WRITE, REG_IMAGE_HEIGHT, 1, 0, EXP_PREDICTED, 0, 0},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'sh0F0F, EXP_NONE, 0, 0},
    // 1x1 kernel on a 1x1 plane: every sample is its own result
    '{DO_WRITE, REG_KERNEL_HEIGHT, 1, 0, EXP_PREDICTED, 0, 0},
    '{DO_WRITE, REG_KERNEL_WIDTH, 1, 0, EXP_PREDICTED, 0, 0},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'sh7FFF, EXP_VALUE, 16'sh7FFF, 1},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'sh8000, EXP_VALUE, 16'sh8000, 1},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'sh0000, EXP_VALUE, 16'sh0000, 1},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'shFFFF, EXP_VALUE, 16'shFFFF, 1},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'sh5555, EXP_VALUE, 16'sh5555, 1},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'shAAAA, EXP_VALUE, 16'shAAAA, 1},
    // out of range: kernel 0 -> 1, kernel 15 -> 8, sizes 0 -> 1
    '{DO_WRITE, REG_KERNEL_HEIGHT, 13'h1FF0, 0, EXP_PREDICTED, 0, 0},
    '{DO_WRITE, REG_KERNEL_WIDTH, 13'h000F, 0, EXP_PREDICTED, 0, 0},
    '{DO_WRITE, REG_IMAGE_WIDTH, 0, 0, EXP_PREDICTED, 0, 0},
    '{DO_WRITE, REG_IMAGE_HEIGHT, 0, 0, EXP_PREDICTED, 0, 0},
    // kernel wider than the image: the plane never completes a window
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'sh3C3C, EXP_NONE, 0, 0},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'shC3C3, EXP_NONE, 0, 0},
    // largest sizes, with clamping from above
    '{DO_WRITE, REG_KERNEL_HEIGHT, 9, 0, EXP_PREDICTED, 0, 0},
    '{DO_WRITE, REG_IMAGE_WIDTH, 13'h07FF, 0, EXP_PREDICTED, 0, 0},
    '{DO_WRITE, REG_IMAGE_HEIGHT, 13'h1FFF, 0, EXP_PREDICTED, 0, 0},
    '{DO_WRITE, REG_KERNEL_WIDTH, 8, 0, EXP_PREDICTED, 0, 0},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'sh7FFF, EXP_NONE, 0, 0},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'sh8000, EXP_NONE, 0, 0},
    '{DO_ALIGN, REG_KERNEL_HEIGHT, 0, 0, EXP_PREDICTED, 0, 0},
    // 2x2 kernel over a 3x3 plane
    '{DO_WRITE, REG_KERNEL_HEIGHT, 2, 0, EXP_PREDICTED, 0, 0},
    '{DO_WRITE, REG_KERNEL_WIDTH, 2, 0, EXP_PREDICTED, 0, 0},
    '{DO_WRITE, REG_IMAGE_WIDTH, 3, 0, EXP_PREDICTED, 0, 0},
    '{DO_WRITE, REG_IMAGE_HEIGHT, 3, 0, EXP_PREDICTED, 0, 0},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'sh0100, EXP_PREDICTED, 0, 0},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'sh0500, EXP_PREDICTED, 0, 0},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'shFD00, EXP_PREDICTED, 0, 0},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'sh0700, EXP_PREDICTED, 0, 0},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'shF800, EXP_PREDICTED, 0, 0},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'sh0200, EXP_PREDICTED, 0, 0},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'sh0000, EXP_PREDICTED, 0, 0},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'sh0400, EXP_PREDICTED, 0, 0},
    '{DO_SAMPLE, REG_KERNEL_HEIGHT, 0, 16'sh0900, EXP_PREDICTED, 0, 0}
  };

  function automatic int bound(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the pooling state by one sample; returns 1 when a window completes
  function automatic bit pool_step(input logic signed [SBITS-1:0] s,
                                   output logic signed [SBITS-1:0] best,
                                   output logic last);
    int kh, kw, w, h, col, row;
    bit signed [SBITS-1:0] cmax;
    bit hit;
    kh = bound(kh_reg, 1, MAXK);
    kw = bound(kw_reg, 1, MAXK);
    w  = bound(w_reg, 1, MAXW);
    h  = bound(h_reg, 1, HEIGHT_LIMIT);
    col = col_pos % MAXW;
    row = row_pos;
    cmax = s;
    for (int j = 0; j + 1 < kh; j++)
      if (col_hist[j][col] > cmax) cmax = col_hist[j][col];
    for (int j = MAXK - 1; j > 1; j--)
      col_hist[j-1][col] = col_hist[j-2][col];
    col_hist[0][col] = s;
    for (int j = MAXK - 1; j > 0; j--)
      colmax_win[j] = colmax_win[j-1];
    colmax_win[0] = cmax;
    hit  = (row + 1 >= kh) && (col + 1 >= kw) && (row < h) && (col < w);
    best = '0;
    last = 1'b0;
    if (hit) begin
      best = colmax_win[0];
      for (int j = 1; j < kw; j++)
        if (colmax_win[j] > best) best = colmax_win[j];
      last = (row + 1 >= h) && (col + 1 >= w);
    end
    // a position beyond a shrunk size wraps on this advance
    col = col_pos + 1;
    if (col >= w) begin
      col = 0;
      row = row_pos + 1;
      if (row >= h) row = 0;
      row_pos = row;
    end
    col_pos = col;
    return hit;
  endfunction

  function automatic logic signed [SBITS-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return 16'($urandom_range(16)) - 16'd8;  // narrow spread, plenty of ties
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_kernel();
    if ($urandom_range(9) == 0) return 13'($urandom);
    return 13'($urandom_range(1, MAXK));
  endfunction

  task automatic note_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic drain(input int extra);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_KERNEL_HEIGHT: kh_reg = data[KERNEL_REG_BITS-1:0];
      REG_KERNEL_WIDTH:  kw_reg = data[KERNEL_REG_BITS-1:0];
      REG_IMAGE_WIDTH:   w_reg  = data[WIDTH_REG_BITS-1:0];
      REG_IMAGE_HEIGHT:  h_reg  = data[HEIGHT_REG_BITS-1:0];
    endcase
    writes_done++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [SBITS-1:0] s, output bit hit,
                             output pooled_t res);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
    hit = pool_step(s, res.value, res.last);
    if (hit) pending.push_back(res);
    samples_sent++;
  endtask

  task automatic feed(input int n);
    bit hit;
    pooled_t res;
    repeat (n) send_sample(pick_sample(), hit, res);
  endtask

  // Collapse the plane to 1x1 so the raster position wraps to the origin
  task automatic return_to_origin();
    if (col_pos != 0 || row_pos != 0) begin
      drain(DRAIN);
      write_reg(REG_IMAGE_WIDTH, 13'd1);
      write_reg(REG_IMAGE_HEIGHT, 13'd1);
      while (col_pos != 0 || row_pos != 0) feed(1);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("max_pool_2d_stream_test: FAIL");
    $finish;
  end

  // Output side: random stalls, plus a counted hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cnt > 0) begin
        out_ready_i <= 1'b0;
        hold_cnt--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    pooled_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending.size() == 0) begin
        note_mismatch($sformatf("unexpected result %h last %b", max_value_o,
                                last_of_plane_o));
      end else begin
        want = pending.pop_front();
        if (max_value_o !== want.value)
          note_mismatch($sformatf("max_value %h, expected %h", max_value_o, want.value));
        if (last_of_plane_o !== want.last)
          note_mismatch($sformatf("last_of_plane %b, expected %b", last_of_plane_o,
                                  want.last));
      end
    end
  end

  initial begin
    bit hit;
    pooled_t res;
    int phase;
    int planes;
    int n;
    int stop_at;
    bit wide;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_KERNEL_HEIGHT;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      case (plan[i].kind)
        DO_WRITE: begin
          drain(DRAIN);
          write_reg(plan[i].idx, plan[i].data);
        end
        DO_ALIGN: return_to_origin();
        DO_SAMPLE: begin
          send_sample(plan[i].sample, hit, res);
          if (plan[i].chk == EXP_NONE && hit)
            note_mismatch($sformatf("table step %0d: result predicted where none is due", i));
          if (plan[i].chk == EXP_VALUE &&
              (!hit || res.value !== plan[i].value || res.last !== plan[i].last))
            note_mismatch($sformatf("table step %0d: predictor disagrees with table", i));
        end
      endcase
    end

    // Every sample pooled on an 8x8 plane; output held off so the block backs up
    drain(DRAIN);
    write_reg(REG_KERNEL_HEIGHT, 13'd1);
    write_reg(REG_KERNEL_WIDTH, 13'd1);
    write_reg(REG_IMAGE_WIDTH, 13'd8);
    write_reg(REG_IMAGE_HEIGHT, 13'd8);
    hold_cnt = HOLD_CYCLES;
    feed(32);
    drain(0);
    feed(32);

    phase = 0;
    stop_at = samples_sent + RANDOM_ITEMS;
    while (samples_sent < stop_at) begin
      phase++;
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      wide = (phase == 3);
      drain(DRAIN);
      if (wide) begin
        // one full-width row; a single beat per column
        write_reg(REG_KERNEL_HEIGHT, 13'd1);
        write_reg(REG_KERNEL_WIDTH, pick_kernel());
        write_reg(REG_IMAGE_WIDTH, 13'(MAXW));
        write_reg(REG_IMAGE_HEIGHT, 13'd1);
      end else begin
        if ($urandom_range(3) != 0) write_reg(REG_KERNEL_HEIGHT, pick_kernel());
        if ($urandom_range(3) != 0) write_reg(REG_KERNEL_WIDTH, pick_kernel());
        if ($urandom_range(3) != 0)
          write_reg(REG_IMAGE_WIDTH,
                    13'(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 16)));
        if ($urandom_range(3) != 0)
          write_reg(REG_IMAGE_HEIGHT,
                    13'(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10)));
      end
      planes = wide ? 1 : $urandom_range(1, 3);
      repeat (planes) begin
        n = bound(w_reg, 1, MAXW) * bound(h_reg, 1, HEIGHT_LIMIT);
        // now and then a plane is cut short and the next setting lands mid-plane
        if (!wide && n > 1 && $urandom_range(7) == 0) n = $urandom_range(1, n - 1);
        if (n > stop_at - samples_sent) n = stop_at - samples_sent;
        feed(n);
      end
      return_to_origin();
    end

    drain(DRAIN);
    $display("%0d samples sent, %0d pooled results checked, %0d register writes",
             samples_sent, results_seen, writes_done);
    $display("kernels 1 to 8, clamped register values, cut planes, long output hold-off");
    if (errors == 0) begin
      $display("max_pool_2d_stream_test: PASS");
    end else begin
      $display("max_pool_2d_stream_test: FAIL");
    end
    $finish;
  end

endmodule

// File: max_pool_2d_stream.f
hdl/mp2s_pkg.sv
hdl/mp2s_line_store.sv
hdl/mp2s_cell.sv
hdl/mp2s_max_tree.sv
hdl/max_pool_2d_stream.sv
verif/max_pool_2d_stream_test.sv
